// ===== sv/uerws_pkg.sv =====
// types and constants shared by the user event ring window search block
// no dependencies; imported by uerws_window and user_event_ring_window_search
package uerws_pkg;

   localparam int EVENT_SLOTS = 64;
   localparam int SLOT_W      = $clog2(EVENT_SLOTS);
   localparam int CNT_W       = $clog2(EVENT_SLOTS + 1);
   localparam int TIME_W      = 48;
   localparam int CODE_W      = 8;
   localparam int WLEN_W      = 32;
   localparam int SUM_W       = 64;
   localparam int IDX_OUT_W   = 6;

   localparam logic [WLEN_W-1:0] WLEN_RESET = 32'd1000000;
   localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_SEARCH = 2'd1,
      CMD_LAST   = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_WIN1,
      ST_WIN2,
      ST_WALK,
      ST_RESULT
   } state_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [TIME_W-1:0] event_time;
      logic [TIME_W-1:0] now_time;
      logic [CODE_W-1:0] event_code;
      logic [TIME_W-1:0] query_time;
      logic [TIME_W-1:0] max_delay;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic [IDX_OUT_W-1:0] slot_index;
      logic [TIME_W-1:0]    found_delay;
      logic [TIME_W-1:0]    found_time;
      logic [WLEN_W-1:0]    window_added;
      logic [SUM_W-1:0]     window_total;
      logic [WLEN_W-1:0]    event_count;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0] time_val;
      logic [CODE_W-1:0] code;
   } slot_type;

   typedef struct packed {
      logic              start;
      logic [TIME_W-1:0] now_time;
   } win_req_type;

   typedef struct packed {
      logic [WLEN_W-1:0] window_added;
      logic [SUM_W-1:0]  window_total;
   } win_stat_type;

endpackage

// ===== sv/uerws_window.sv =====
// open-window accounting: three-stage update of window end and aggregated total
// depends on uerws_pkg
module uerws_window (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [31:0]             window_length,
   input  uerws_pkg::win_req_type  win_req,
   output uerws_pkg::win_stat_type win_stat
);
   import uerws_pkg::*;

   logic [TIME_W-1:0] end_ff, end_in;
   logic              started_ff, started_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              s1_vld_ff, s2_vld_ff;
   logic              grow_ff, after_ff;
   logic [WLEN_W-1:0] gap_ff;
   logic [TIME_W-1:0] new_end_ff;
   logic [WLEN_W-1:0] added_ff, added_in;

   logic [TIME_W-1:0] eff_end;
   logic [TIME_W:0]   new_end;
   logic [TIME_W-1:0] gap;
   logic              grow, after;

   // stage 1: compare the open window against the new one
   always_comb begin
      eff_end = started_ff ? end_ff : win_req.now_time;
      new_end = {1'b0, win_req.now_time} + (TIME_W+1)'(window_length);
      grow    = {1'b0, eff_end} <= new_end;
      after   = eff_end < win_req.now_time;
      gap     = eff_end - win_req.now_time;
   end

   // stage 2 and 3: added amount, then running total
   always_comb begin
      added_in   = added_ff;
      end_in     = end_ff;
      started_in = started_ff | win_req.start;
      sum_in     = sum_ff;
      if (s1_vld_ff) begin
         if (grow_ff) begin
            added_in = after_ff ? window_length : window_length - gap_ff;
            end_in   = new_end_ff;
         end else begin
            added_in = '0;
         end
      end
      if (s2_vld_ff) begin
         sum_in = sum_ff + SUM_W'(added_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         started_ff <= 1'b0;
         end_ff     <= '0;
         sum_ff     <= '0;
         added_ff   <= '0;
      end else begin
         s1_vld_ff  <= win_req.start;
         s2_vld_ff  <= s1_vld_ff;
         started_ff <= started_in;
         end_ff     <= end_in;
         sum_ff     <= sum_in;
         added_ff   <= added_in;
      end
   end

   always_ff @(posedge clock) begin
      if (win_req.start) begin
         grow_ff    <= grow;
         after_ff   <= after;
         gap_ff     <= gap[WLEN_W-1:0];
         new_end_ff <= new_end[TIME_W] ? TIME_MAX : new_end[TIME_W-1:0];
      end
   end

   assign win_stat.window_added = added_ff;
   assign win_stat.window_total = sum_ff;

   a_added_bounded: assert property (@(posedge clock) disable iff (reset)
      $past(s1_vld_ff) && !$past(reset) |-> added_ff <= window_length)
      else $error("window added exceeds window length");

   a_sum_only_on_add: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(s2_vld_ff) |-> $stable(sum_ff))
      else $error("window total changed without an add");

   a_no_sum_before_start: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> sum_ff == '0)
      else $error("window total nonzero before first window");

endmodule

// ===== sv/user_event_ring_window_search.sv =====
// top level of the user event ring: slot memory, walk sequencer, result register
// depends on uerws_pkg and uerws_window
//
// Keeps the last EVENT_SLOTS user events (timestamp, code) in a ring memory with
// a registered read, and accounts open-window time per added event. Items are
// handled one at a time. An add does the slot write, then the three-stage window
// update in uerws_window, before it answers. A search or last-event query walks
// back from the newest slot one memory read per cycle; an empty ring or the
// unused command goes straight to the result state. The result sits in an output
// register, and a new item is taken while it waits. Slots never written read as
// time 0 and code 0 through per-slot valid bits cleared at reset, so no clearing
// pass is needed. csr_wr_data sets the window length and must only be written
// while the block is idle.
module user_event_ring_window_search (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  uerws_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output uerws_pkg::rsp_type rsp_data,
   input  logic               csr_wr_en,
   input  logic [31:0]        csr_wr_data
);
   import uerws_pkg::*;

   // window length register
   logic [WLEN_W-1:0] wlen_ff;

   // control state
   state_type         state_ff, state_in;
   logic              nonempty_ff;
   logic [SLOT_W-1:0] newest_ff;
   logic [WLEN_W-1:0] count_ff;
   logic [EVENT_SLOTS-1:0] slot_vld_ff;

   // accepted item
   req_type           item_ff;

   // slot memory and its registered read port
   slot_type          mem [EVENT_SLOTS];
   slot_type          rd_data_ff;
   logic              rd_vld_ff;
   logic [SLOT_W-1:0] rd_tag_ff;
   logic              rd_live_ff, rd_live_in;

   // walk pointers
   logic [SLOT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0]  issue_cnt_ff, eval_cnt_ff;

   // pending result
   logic              res_found_ff;
   logic [SLOT_W-1:0] res_slot_ff;
   logic [TIME_W-1:0] res_delay_ff, res_time_ff;

   // output register
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   // fsm outputs
   logic              accept, mem_we, load_rsp, walk_done, walk_hit;
   logic [SLOT_W-1:0] wr_slot;

   // evaluation of the slot read in the previous cycle
   logic [TIME_W-1:0] ev_time;
   logic [CODE_W-1:0] ev_code;
   logic [TIME_W:0]   age;
   logic              too_old, code_hit, last_slot;

   win_req_type       win_req;
   win_stat_type      win_stat;

   function automatic logic code_match(input logic [CODE_W-1:0] c);
      return (c == CODE_W'(1)) || (c == CODE_W'(2)) || (c == CODE_W'(3));
   endfunction

   function automatic logic [SLOT_W-1:0] prev_slot(input logic [SLOT_W-1:0] s);
      return (s == '0) ? SLOT_W'(EVENT_SLOTS - 1) : s - 1'b1;
   endfunction

   // slot to write: first add goes to slot 0, later ones follow the newest
   always_comb begin
      if (!nonempty_ff) begin
         wr_slot = '0;
      end else if (newest_ff == SLOT_W'(EVENT_SLOTS - 1)) begin
         wr_slot = '0;
      end else begin
         wr_slot = newest_ff + 1'b1;
      end
   end

   // age check and code check on the slot under evaluation
   always_comb begin
      ev_time   = rd_vld_ff ? rd_data_ff.time_val : '0;
      ev_code   = rd_vld_ff ? rd_data_ff.code : '0;
      age       = {1'b0, item_ff.query_time} - {1'b0, ev_time};
      // a negative age is below any limit
      too_old   = (item_ff.cmd == CMD_SEARCH) && !age[TIME_W]
                  && (age[TIME_W-1:0] >= item_ff.max_delay);
      code_hit  = code_match(ev_code);
      last_slot = eval_cnt_ff == CNT_W'(EVENT_SLOTS - 1);
      walk_hit  = rd_live_ff && !too_old && code_hit;
      walk_done = rd_live_ff && (too_old || code_hit || last_slot);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_data.cmd) inside
                  CMD_ADD:             state_in = ST_ADD;
                  CMD_SEARCH, CMD_LAST: state_in = nonempty_ff ? ST_WALK : ST_RESULT;
                  default:             state_in = ST_RESULT;
               endcase
            end
         end
         ST_ADD:    state_in = ST_WIN1;
         ST_WIN1:   state_in = ST_WIN2;
         ST_WIN2:   state_in = ST_RESULT;
         ST_WALK: begin
            if (walk_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_ready = 1'b0;
      mem_we    = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_ADD:    mem_we    = 1'b1;
         ST_RESULT: load_rsp  = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   assign accept = req_valid && req_ready;

   // walk issues one read a cycle until every slot has been requested
   always_comb begin
      ptr_in     = ptr_ff;
      rd_live_in = 1'b0;
      if (accept) begin
         ptr_in = newest_ff;
      end else if (state_ff == ST_WALK) begin
         ptr_in     = prev_slot(ptr_ff);
         rd_live_in = (state_in == ST_WALK) && (issue_cnt_ff < CNT_W'(EVENT_SLOTS));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wlen_ff      <= WLEN_RESET;
         nonempty_ff  <= 1'b0;
         newest_ff    <= '0;
         count_ff     <= '0;
         slot_vld_ff  <= '0;
         rd_live_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_live_ff <= rd_live_in;
         if (csr_wr_en) begin
            wlen_ff <= csr_wr_data;
         end
         if (mem_we) begin
            nonempty_ff          <= 1'b1;
            newest_ff            <= wr_slot;
            count_ff             <= count_ff + 1'b1;
            slot_vld_ff[wr_slot] <= 1'b1;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_slot] <= '{time_val: item_ff.event_time, code: item_ff.event_code};
      end
      rd_data_ff <= mem[ptr_ff];
      rd_vld_ff  <= slot_vld_ff[ptr_ff];
      rd_tag_ff  <= ptr_ff;
   end

   // item, walk counters and pending result
   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (accept) begin
         item_ff      <= req_data;
         issue_cnt_ff <= '0;
         eval_cnt_ff  <= '0;
         res_found_ff <= 1'b0;
         res_slot_ff  <= '0;
         res_delay_ff <= '0;
         res_time_ff  <= '0;
      end else begin
         if (state_ff == ST_WALK) begin
            issue_cnt_ff <= issue_cnt_ff + 1'b1;
         end
         if (rd_live_ff) begin
            eval_cnt_ff <= eval_cnt_ff + 1'b1;
         end
         if (walk_hit) begin
            res_found_ff <= 1'b1;
            res_slot_ff  <= rd_tag_ff;
            res_delay_ff <= (item_ff.cmd == CMD_SEARCH) ? age[TIME_W-1:0] : '0;
            res_time_ff  <= ev_time;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ff.found        <= res_found_ff;
         rsp_ff.slot_index   <= IDX_OUT_W'({{IDX_OUT_W{1'b0}}, res_slot_ff});
         rsp_ff.found_delay  <= res_delay_ff;
         rsp_ff.found_time   <= res_time_ff;
         rsp_ff.window_added <= (item_ff.cmd == CMD_ADD) ? win_stat.window_added : '0;
         rsp_ff.window_total <= win_stat.window_total;
         rsp_ff.event_count  <= count_ff;
      end
   end

   assign win_req.start    = mem_we;
   assign win_req.now_time = item_ff.now_time;

   uerws_window u_window (
      .clock         (clock),
      .reset         (reset),
      .window_length (wlen_ff),
      .win_req       (win_req),
      .win_stat      (win_stat)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("result item raised outside the result state");

   a_walk_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> nonempty_ff)
      else $error("walk started on an empty ring");

   a_newest_written: assert property (@(posedge clock) disable iff (reset)
      nonempty_ff |-> slot_vld_ff[newest_ff])
      else $error("newest slot was never written");

endmodule

// ===== dv/user_event_ring_window_search_tb.sv =====
// testbench for user_event_ring_window_search: directed and random items against a local ring model
// depends on uerws_pkg and the block's RTL; needs no files or arguments
module user_event_ring_window_search_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import uerws_pkg::*;

   // run pacing
   localparam int unsigned DRAIN_CYCLES = 70;    // longer than the slowest walk
   localparam int unsigned HOLD_CYCLES  = 300;   // long output stall in the backpressure test
   localparam int unsigned QUIET_LIMIT  = 3000;  // cycles with no item moving before we give up

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   user_event_ring_window_search DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // local copy of the ring and window accounting state
   // ---------------------------------------------------------------------
   logic [TIME_W-1:0] ring_time [EVENT_SLOTS];
   logic [CODE_W-1:0] ring_code [EVENT_SLOTS];
   int unsigned       ring_head;
   bit                ring_used;
   logic [TIME_W-1:0] open_end;
   bit                open_started;
   logic [SUM_W-1:0]  open_total;
   logic [31:0]       add_tally;
   logic [WLEN_W-1:0] win_len;

   rsp_type awaited_answers [$];   // one predicted answer per accepted item, oldest first
   rsp_type head_answer;

   int unsigned error_count;
   int unsigned items_sent;
   int unsigned answers_checked;
   int unsigned hits_seen;
   int unsigned quiet_cycles;

   // idle rates in percent and the output stall countdown
   int unsigned snd_idle_pct;
   int unsigned rcv_idle_pct;
   int unsigned hold_left;

   // running time base for random traffic
   logic [TIME_W-1:0] traffic_clock;

   // codes 1 to 3 are the user events a search is looking for
   function automatic bit is_user_code(input logic [CODE_W-1:0] c);
      return (c == 8'd1) || (c == 8'd2) || (c == 8'd3);
   endfunction

   task automatic clear_ring_state();
      for (int i = 0; i < EVENT_SLOTS; i++) begin
         ring_time[i] = '0;
         ring_code[i] = '0;
      end
      ring_head    = 0;
      ring_used    = 1'b0;
      open_end     = '0;
      open_started = 1'b0;
      open_total   = '0;
      add_tally    = '0;
      win_len      = WLEN_RESET;
   endtask

   // advances the local state by one item and returns the answer the block must give
   function automatic rsp_type compute_ring_answer(input req_type r);
      rsp_type       a;
      logic [TIME_W:0] new_end;
      longint        age;
      longint        limit;
      int unsigned   s;
      int unsigned   n;
      a = '0;
      case (r.cmd)
         CMD_ADD: begin
            // first add lands in slot 0, later ones in the slot after the newest
            if (!ring_used) begin
               ring_head = 0;
               ring_used = 1'b1;
            end else begin
               ring_head = (ring_head + 1) % EVENT_SLOTS;
            end
            ring_time[ring_head] = r.event_time;
            ring_code[ring_head] = r.event_code;
            add_tally = add_tally + 1;

            // first window counts in full
            if (!open_started) begin
               open_end     = r.now_time;
               open_started = 1'b1;
            end
            new_end = {1'b0, r.now_time} + (TIME_W+1)'(win_len);
            // a window wholly inside the open one adds nothing
            if ({1'b0, open_end} <= new_end) begin
               if (open_end < r.now_time)
                  a.window_added = win_len;
               else
                  a.window_added = win_len - WLEN_W'(open_end - r.now_time);
               open_total = open_total + SUM_W'(a.window_added);
               open_end   = new_end[TIME_W] ? TIME_MAX : new_end[TIME_W-1:0];
            end
         end
         CMD_SEARCH: begin
            if (ring_used) begin
               s     = ring_head;
               limit = $signed({16'b0, r.max_delay});
               for (n = 0; n < EVENT_SLOTS; n++) begin
                  // an event later than the query has a negative age and never stops the walk
                  age = $signed({16'b0, r.query_time}) - $signed({16'b0, ring_time[s]});
                  if (age >= limit)
                     break;
                  if (is_user_code(ring_code[s])) begin
                     a.found       = 1'b1;
                     a.slot_index  = s[IDX_OUT_W-1:0];
                     a.found_delay = age[TIME_W-1:0];
                     a.found_time  = ring_time[s];
                     break;
                  end
                  s = (s == 0) ? EVENT_SLOTS - 1 : s - 1;
               end
            end
         end
         CMD_LAST: begin
            if (ring_used) begin
               s = ring_head;
               for (n = 0; n < EVENT_SLOTS; n++) begin
                  if (is_user_code(ring_code[s])) begin
                     a.found      = 1'b1;
                     a.slot_index = s[IDX_OUT_W-1:0];
                     a.found_time = ring_time[s];
                     break;
                  end
                  s = (s == 0) ? EVENT_SLOTS - 1 : s - 1;
               end
            end
         end
         default: ;   // unused command leaves everything alone
      endcase
      a.window_total = open_total;
      a.event_count  = add_tally;
      return a;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   function automatic logic [TIME_W-1:0] rand_time();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[TIME_W-1:0];
   endfunction

   function automatic req_type ring_item(input cmd_type cmd, input logic [TIME_W-1:0] ev_time,
                                         input logic [TIME_W-1:0] now, input logic [CODE_W-1:0] code,
                                         input logic [TIME_W-1:0] query,
                                         input logic [TIME_W-1:0] delay);
      req_type r;
      r.cmd        = cmd;
      r.event_time = ev_time;
      r.now_time   = now;
      r.event_code = code;
      r.query_time = query;
      r.max_delay  = delay;
      return r;
   endfunction

   // mostly a realistic event stream on a rising time base, with some noise mixed in
   function automatic req_type next_traffic_item();
      req_type     r;
      int unsigned pick;
      traffic_clock = traffic_clock + TIME_W'($urandom_range(400000));
      // rare forward jumps keep the window logic alive while moving the upper time bits
      if ($urandom_range(149) == 0)
         traffic_clock = traffic_clock + (rand_time() >> 8);

      pick  = $urandom_range(99);
      r.cmd = (pick < 45) ? CMD_ADD : (pick < 80) ? CMD_SEARCH : (pick < 93) ? CMD_LAST : CMD_NOP;

      // now sometimes lags so the new window overlaps or sits inside the open one
      r.now_time = ($urandom_range(99) < 15)
                   ? traffic_clock - TIME_W'($urandom_range(2000000))
                   : traffic_clock;
      r.event_time = ($urandom_range(9) == 0) ? rand_time()
                     : traffic_clock - TIME_W'($urandom_range(300000));
      pick = $urandom_range(9);
      if (pick < 5)
         r.event_code = CODE_W'($urandom_range(1, 3));
      else if (pick < 8)
         r.event_code = '0;
      else
         r.event_code = CODE_W'($urandom_range(255));
      r.query_time = ($urandom_range(9) == 0) ? rand_time()
                     : traffic_clock + TIME_W'($urandom_range(50000));
      pick = $urandom_range(9);
      if (pick < 7)
         r.max_delay = TIME_W'($urandom_range(2000000));
      else if (pick < 8)
         r.max_delay = '0;
      else if (pick < 9)
         r.max_delay = TIME_MAX;
      else
         r.max_delay = rand_time();
      return r;
   endfunction

   // offers one item from a falling edge, holds it until accepted, and ends on a falling edge
   task automatic send_ring_item(input req_type item);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      awaited_answers.push_back(compute_ring_answer(item));
      items_sent++;
      @(negedge clock);
   endtask

   // stops offering and waits until every predicted answer has come back
   task automatic drain_ring();
      req_valid <= 1'b0;
      while (awaited_answers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // register writes only happen with the block idle
   task automatic set_window_length(input logic [WLEN_W-1:0] len);
      drain_ring();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      win_len = len;
   endtask

   // ---------------------------------------------------------------------
   // result side: random stalls plus a counted long hold for backpressure
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endtask

   // every accepted result is matched against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_answers.size() == 0) begin
            $error("result with no item outstanding: %p", rsp_data);
            error_count++;
         end else begin
            head_answer = awaited_answers.pop_front();
            compare_field("found",        64'(head_answer.found),
                          64'(rsp_data.found));
            compare_field("slot_index",   64'(head_answer.slot_index),
                          64'(rsp_data.slot_index));
            compare_field("found_delay",  64'(head_answer.found_delay),
                          64'(rsp_data.found_delay));
            compare_field("found_time",   64'(head_answer.found_time),
                          64'(rsp_data.found_time));
            compare_field("window_added", 64'(head_answer.window_added),
                          64'(rsp_data.window_added));
            compare_field("window_total", head_answer.window_total, rsp_data.window_total);
            compare_field("event_count",  64'(head_answer.event_count),
                          64'(rsp_data.event_count));
            answers_checked++;
            if (head_answer.found)
               hits_seen++;
         end
      end
   end

   // watchdog: a hang shows up as a long run of cycles with nothing accepted
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: %0d cycles with no item accepted, %0d answers still awaited",
                  quiet_cycles, awaited_answers.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // search, last-event query and the unused command on an empty ring
   task automatic test_empty_ring();
      send_ring_item(ring_item(CMD_SEARCH, '0, '0, '0, TIME_MAX, TIME_MAX));
      send_ring_item(ring_item(CMD_LAST, '0, '0, '0, '0, '0));
      send_ring_item(ring_item(CMD_NOP, TIME_MAX, TIME_MAX, 8'hff, TIME_MAX, TIME_MAX));
      drain_ring();
   endtask

   // first window, partial overlap, window inside the open one, window after it
   task automatic test_window_accounting();
      send_ring_item(ring_item(CMD_ADD, '0, 48'd1000, 8'd1, '0, '0));
      send_ring_item(ring_item(CMD_ADD, TIME_MAX, 48'd1500, 8'd2, '0, '0));
      send_ring_item(ring_item(CMD_ADD, 48'd100, '0, 8'd0, '0, '0));
      send_ring_item(ring_item(CMD_ADD, 48'd200, 48'd5000000, 8'd3, '0, '0));
      drain_ring();
   endtask

   // hit, stop on age, zero and full-range delay, events later than the query
   task automatic test_recent_search();
      send_ring_item(ring_item(CMD_ADD, 48'd300, 48'd5000100, 8'hff, '0, '0));
      send_ring_item(ring_item(CMD_ADD, 48'd400, 48'd5000200, 8'd4, '0, '0));
      send_ring_item(ring_item(CMD_SEARCH, '0, '0, '0, 48'd450, 48'd1000));
      send_ring_item(ring_item(CMD_SEARCH, '0, '0, '0, 48'd450, 48'd100));
      send_ring_item(ring_item(CMD_SEARCH, '0, '0, '0, 48'd450, '0));
      send_ring_item(ring_item(CMD_SEARCH, '0, '0, '0, 48'd50, '0));
      send_ring_item(ring_item(CMD_SEARCH, '0, '0, '0, TIME_MAX, TIME_MAX));
      send_ring_item(ring_item(CMD_LAST, '0, '0, '0, '0, '0));
      drain_ring();
   endtask

   // zero and all-ones window length
   task automatic test_length_extremes();
      set_window_length('0);
      send_ring_item(ring_item(CMD_ADD, 48'd7000000, 48'd7000000, 8'd1, '0, '0));
      set_window_length('1);
      send_ring_item(ring_item(CMD_ADD, 48'd7000001, 48'd7000001, 8'd2, '0, '0));
      drain_ring();
   endtask

   // result side holds off long enough for the block to fill and stall its input
   task automatic test_backpressure();
      int unsigned k;
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      @(posedge clock);
      hold_left = HOLD_CYCLES;
      @(negedge clock);
      for (k = 0; k < 24; k++)
         send_ring_item(next_traffic_item());
      drain_ring();
   endtask

   task automatic test_random_traffic(input int unsigned count, input int unsigned snd_pct,
                                      input int unsigned rcv_pct, input logic [WLEN_W-1:0] len);
      int unsigned k;
      set_window_length(len);
      snd_idle_pct = snd_pct;
      rcv_idle_pct = rcv_pct;
      for (k = 0; k < count; k++)
         send_ring_item(next_traffic_item());
      drain_ring();
   endtask

   // window end pinned at the top of the time range; run last since it never comes down
   task automatic test_window_saturation();
      set_window_length(WLEN_RESET);
      send_ring_item(ring_item(CMD_ADD, TIME_MAX, TIME_MAX - 48'd10, 8'd1, '0, '0));
      send_ring_item(ring_item(CMD_ADD, TIME_MAX - 48'd5, TIME_MAX, 8'd2, '0, '0));
      send_ring_item(ring_item(CMD_LAST, '0, '0, '0, '0, '0));
      send_ring_item(ring_item(CMD_SEARCH, '0, '0, '0, TIME_MAX, TIME_MAX));
      drain_ring();
   endtask

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_ready    = 1'b0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      hold_left    = 0;
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      error_count  = 0;
      items_sent   = 0;
      quiet_cycles = 0;
      answers_checked = 0;
      hits_seen       = 0;
      traffic_clock   = 48'd5000000000;
      clear_ring_state();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_ring();
      test_window_accounting();
      test_recent_search();
      test_length_extremes();
      test_backpressure();
      // sender light / receiver heavy idling, then the reverse, then none
      test_random_traffic(500, 17, 79, $urandom_range(1, 3000000));
      test_random_traffic(500, 79, 17, $urandom_range(1, 5000000));
      test_random_traffic(500, 0, 0, $urandom());
      test_window_saturation();

      $display("covered %0d items and %0d results (%0d hits) across empty ring, wrap and search",
               items_sent, answers_checked, hits_seen);
      $display("window lengths zero, all ones and random, plus a %0d-cycle output stall",
               HOLD_CYCLES);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
sv/uerws_pkg.sv
sv/uerws_window.sv
sv/user_event_ring_window_search.sv
dv/user_event_ring_window_search_tb.sv
